FILE: rtl/core/ple_pkg.sv
`default_nettype none
package ple_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int OP_W         = 3;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 6;
   localparam int STATUS_W     = 3;
   localparam int LEN_W        = 7;

   localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_POS  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_RM_HEAD  = 3'd3;
   localparam logic [OP_W-1:0] OP_RM_POS   = 3'd4;
   localparam logic [OP_W-1:0] OP_RM_TAIL  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/core/ple_ctrl.sv
`default_nettype none
module ple_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ple_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/ple_datapath.sv
`default_nettype none
module ple_datapath #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ple_pkg::cmd_type                    cmd,
   input  wire logic [ple_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]  req_item_value,
   input  wire logic [ple_pkg::POS_W-1:0]           req_position,
   output logic [ple_pkg::STATUS_W-1:0]             rsp_status,
   output logic [ple_pkg::LEN_W-1:0]                rsp_new_length,
   output logic signed [ple_pkg::VALUE_W-1:0]       rsp_affected_value
);

   localparam int LEN_W   = ple_pkg::LEN_W;
   localparam int VALUE_W = ple_pkg::VALUE_W;
   localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW      = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0] CAP_X = LEN_W'(CAPACITY);

   logic [ple_pkg::OP_W-1:0]  op_ff;
   logic [VALUE_W-1:0]        val_ff;
   logic [ple_pkg::POS_W-1:0] pos_ff;

   logic [LW-1:0]      len_ff;
   logic [LW-1:0]      len_in;
   logic [VALUE_W-1:0] entries_ff [CAPACITY];
   logic [VALUE_W-1:0] entries_in [CAPACITY];

   logic [ple_pkg::STATUS_W-1:0] status_ff;
   logic [LEN_W-1:0]             new_len_ff;
   logic [VALUE_W-1:0]           affected_ff;

   logic [LEN_W-1:0]             len_x;
   logic [LEN_W-1:0]             pos_x;
   logic [LEN_W-1:0]             at_x;
   logic [LEN_W-1:0]             new_len_x;
   logic                         ins_en;
   logic                         rm_en;
   logic [ple_pkg::STATUS_W-1:0] status;
   logic [VALUE_W-1:0]           value;
   logic [VALUE_W-1:0]           rd_value;

   assign len_x    = LEN_W'(len_ff);
   assign pos_x    = LEN_W'(pos_ff);
   assign rd_value = entries_ff[IW'(at_x)];

   always_comb begin
      ins_en = 1'b0;
      rm_en  = 1'b0;
      at_x   = '0;
      status = ple_pkg::ST_DONE;
      value  = '0;
      unique case (op_ff)
         ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_POS, ple_pkg::OP_INS_TAIL: begin
            if (len_x >= CAP_X) begin
               status = ple_pkg::ST_FULL;
            end else begin
               ins_en = 1'b1;
               value  = val_ff;
               if (op_ff == ple_pkg::OP_INS_HEAD) begin
                  at_x = '0;
               end else if (op_ff == ple_pkg::OP_INS_TAIL) begin
                  at_x = len_x;
               end else if (pos_x == '0 || pos_x < len_x) begin
                  at_x = pos_x;
               end else begin
                  at_x   = len_x;
                  status = ple_pkg::ST_APPENDED;
               end
            end
         end
         ple_pkg::OP_RM_HEAD, ple_pkg::OP_RM_POS, ple_pkg::OP_RM_TAIL: begin
            if (len_x == '0) begin
               status = ple_pkg::ST_EMPTY;
            end else if (op_ff == ple_pkg::OP_RM_HEAD) begin
               rm_en = 1'b1;
               at_x  = '0;
            end else if (op_ff == ple_pkg::OP_RM_TAIL) begin
               rm_en = 1'b1;
               at_x  = len_x - LEN_W'(1);
            end else if (pos_x < len_x) begin
               rm_en = 1'b1;
               at_x  = pos_x;
            end else begin
               status = ple_pkg::ST_NOTFOUND;
            end
         end
         default: begin
            status = ple_pkg::ST_DONE;
         end
      endcase
      if (rm_en) begin
         value = rd_value;
      end
   end

   assign new_len_x = len_x + LEN_W'(ins_en) - LEN_W'(rm_en);
   assign len_in    = LW'(new_len_x);

   // shift chain: each cell takes its left or right neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_comb begin
         entries_in[i] = entries_ff[i];
         if (ins_en && LEN_W'(i) == at_x) begin
            entries_in[i] = val_ff;
         end
         if (i > 0) begin
            if (ins_en && LEN_W'(i) > at_x) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end
         if (i < CAPACITY - 1) begin
            if (rm_en && LEN_W'(i) >= at_x) begin
               entries_in[i] = entries_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         val_ff <= req_item_value;
         pos_ff <= req_position;
      end
      if (cmd.execute) begin
         entries_ff  <= entries_in;
         status_ff   <= status;
         new_len_ff  <= new_len_x;
         affected_ff <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (cmd.execute) begin
         len_ff <= len_in;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_new_length     = new_len_ff;
   assign rsp_affected_value = affected_ff;

endmodule
`default_nettype wire

FILE: rtl/core/positional_list_engine.sv
// A request word is captured in the idle state, the list is updated in the
// exec state, and the response is held in the resp state until not stalled.
// No new request word is taken until the response is taken. Each word goes
// through capture, an update in which the cell chain shifts, then a response hold.
// Reset: synchronous, clears the length and controller; entry storage is
// not cleared and is never read past the length.
`default_nettype none
module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ple_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]  req_item_value,
   input  wire logic [ple_pkg::POS_W-1:0]           req_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ple_pkg::STATUS_W-1:0]             rsp_status,
   output logic [ple_pkg::LEN_W-1:0]                rsp_new_length,
   output logic signed [ple_pkg::VALUE_W-1:0]       rsp_affected_value
);

   ple_pkg::cmd_type cmd;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_op             (req_op),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_status         (rsp_status),
      .rsp_new_length     (rsp_new_length),
      .rsp_affected_value (rsp_affected_value)
   );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

   localparam int CAP          = ple_pkg::CAPACITY_DEF;
   localparam int OP_W         = ple_pkg::OP_W;
   localparam int VALUE_W      = ple_pkg::VALUE_W;
   localparam int POS_W        = ple_pkg::POS_W;
   localparam int STATUS_W     = ple_pkg::STATUS_W;
   localparam int LEN_W        = ple_pkg::LEN_W;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_WORDS = 1250;

   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          position;
   } list_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [LEN_W-1:0]          new_length;
      logic signed [VALUE_W-1:0] affected_value;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_op         = '0;
   logic signed [VALUE_W-1:0]  req_item_value = '0;
   logic [POS_W-1:0]           req_position   = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [LEN_W-1:0]           rsp_new_length;
   logic signed [VALUE_W-1:0]  rsp_affected_value;

   list_request_type pending_words[$];
   list_result_type  predicted_results[$];

   logic signed [VALUE_W-1:0] shadow_list[0:CAP-1];
   int shadow_len   = 0;
   int gen_len      = 0;
   int words_sent   = 0;
   int hold_left    = 0;
   logic hold_armed = 1'b1;
   int cycle_count  = 0;
   int mismatches   = 0;

   positional_list_engine #(.CAPACITY(CAP)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_new_length     (rsp_new_length),
      .rsp_affected_value (rsp_affected_value)
   );

   always #6 clock = ~clock;

   function automatic int idle_phase();
      return (words_sent / 100) % 4;
   endfunction

   function automatic bit sender_idles();
      case (idle_phase())
         1: return $urandom_range(99) < 56;
         3: return $urandom_range(99) < 8;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_phase())
         2: return $urandom_range(99) < 56;
         3: return $urandom_range(99) < 8;
         default: return 1'b0;
      endcase
   endfunction

   // Shadow list update; pushes the response this request should produce.
   function automatic void apply_to_shadow_list(logic [OP_W-1:0] op,
                                                logic signed [VALUE_W-1:0] val,
                                                logic [POS_W-1:0] pos);
      list_result_type res;
      int at;
      int i;
      res.status         = ple_pkg::ST_DONE;
      res.affected_value = '0;
      at = -1;
      case (op)
         ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_POS, ple_pkg::OP_INS_TAIL: begin
            if (shadow_len >= CAP) begin
               res.status = ple_pkg::ST_FULL;
            end else begin
               if (op == ple_pkg::OP_INS_HEAD) begin
                  at = 0;
               end else if (op == ple_pkg::OP_INS_TAIL) begin
                  at = shadow_len;
               end else if (pos == 0 || int'(pos) < shadow_len) begin
                  at = int'(pos);
               end else begin
                  at = shadow_len;
                  res.status = ple_pkg::ST_APPENDED;
               end
               for (i = shadow_len; i > at; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[at] = val;
               shadow_len++;
               res.affected_value = val;
            end
         end
         ple_pkg::OP_RM_HEAD, ple_pkg::OP_RM_POS, ple_pkg::OP_RM_TAIL: begin
            if (shadow_len == 0) begin
               res.status = ple_pkg::ST_EMPTY;
            end else begin
               if (op == ple_pkg::OP_RM_HEAD) begin
                  at = 0;
               end else if (op == ple_pkg::OP_RM_TAIL) begin
                  at = shadow_len - 1;
               end else if (int'(pos) < shadow_len) begin
                  at = int'(pos);
               end else begin
                  res.status = ple_pkg::ST_NOTFOUND;
               end
               if (at >= 0) begin
                  res.affected_value = shadow_list[at];
                  for (i = at; i + 1 < shadow_len; i++)
                     shadow_list[i] = shadow_list[i+1];
                  shadow_len--;
               end
            end
         end
         default: ;
      endcase
      res.new_length = LEN_W'(shadow_len);
      predicted_results.push_back(res);
   endfunction

   // Generation side only tracks the length to aim positions.
   task automatic queue_word(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val,
                             logic [POS_W-1:0] pos);
      list_request_type w;
      w.op         = op;
      w.item_value = val;
      w.position   = pos;
      pending_words.push_back(w);
      case (op)
         ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_POS, ple_pkg::OP_INS_TAIL:
            if (gen_len < CAP) gen_len++;
         ple_pkg::OP_RM_HEAD, ple_pkg::OP_RM_TAIL: if (gen_len > 0) gen_len--;
         ple_pkg::OP_RM_POS: if (gen_len > 0 && int'(pos) < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(bit removal);
      int r;
      int top;
      int p;
      r = $urandom_range(99);
      top = (removal && gen_len > 0) ? gen_len - 1 : gen_len;
      if (r < 70) begin
         p = $urandom_range(top);
      end else if (r < 85) begin
         p = gen_len + $urandom_range(3);
         if (p > 63) p = 63;
      end else begin
         p = $urandom_range(63);
      end
      return POS_W'(p);
   endfunction

   task automatic fill_stimulus();
      int i;
      int ins_pct;
      logic [OP_W-1:0] op;
      bit removal;
      ins_pct = 50;

      queue_word(ple_pkg::OP_RM_HEAD, VAL_MAX, 6'd0);
      queue_word(ple_pkg::OP_RM_POS, VAL_MIN, 6'd0);
      queue_word(ple_pkg::OP_RM_TAIL, -1, 6'd63);
      queue_word(ple_pkg::OP_INS_POS, VAL_MAX, 6'd0);
      queue_word(ple_pkg::OP_INS_POS, VAL_MIN, 6'd63);
      queue_word(ple_pkg::OP_INS_HEAD, '0, 6'd0);
      queue_word(ple_pkg::OP_INS_TAIL, -1, 6'd21);
      queue_word(ple_pkg::OP_INS_POS, 32'sh5555_5555, 6'd2);
      queue_word(ple_pkg::OP_INS_POS, 32'shaaaa_aaaa, 6'd5);
      queue_word(OP_SPARE6, 32'sh1357_9bdf, 6'd63);
      queue_word(OP_SPARE7, -1, 6'd42);
      queue_word(ple_pkg::OP_RM_POS, '0, 6'd6);
      queue_word(ple_pkg::OP_RM_POS, -1, 6'd63);
      queue_word(ple_pkg::OP_RM_POS, '0, 6'd2);
      queue_word(ple_pkg::OP_RM_HEAD, '0, 6'd0);
      queue_word(ple_pkg::OP_RM_TAIL, '0, 6'd0);
      queue_word(ple_pkg::OP_RM_POS, '0, 6'd2);
      queue_word(ple_pkg::OP_RM_POS, '0, 6'd0);
      queue_word(ple_pkg::OP_RM_TAIL, '0, 6'd0);
      queue_word(ple_pkg::OP_INS_TAIL, 32'sh1234_5678, 6'd0);
      queue_word(ple_pkg::OP_RM_HEAD, '0, 6'd0);
      queue_word(ple_pkg::OP_INS_HEAD, 32'sh0f0f_0f0f, 6'd0);
      queue_word(ple_pkg::OP_RM_POS, '0, 6'd0);
      queue_word(ple_pkg::OP_INS_POS, 32'sh7654_3210, 6'd1);
      queue_word(ple_pkg::OP_RM_HEAD, '0, 6'd0);

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 60 == 0) begin
            case ($urandom_range(2))
               0: ins_pct = 85;
               1: ins_pct = 50;
               default: ins_pct = 20;
            endcase
         end
         if ($urandom_range(99) < 3) begin
            op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
         end else if ($urandom_range(99) < ins_pct) begin
            case ($urandom_range(2))
               0: op = ple_pkg::OP_INS_HEAD;
               1: op = ple_pkg::OP_INS_POS;
               default: op = ple_pkg::OP_INS_TAIL;
            endcase
         end else begin
            case ($urandom_range(2))
               0: op = ple_pkg::OP_RM_HEAD;
               1: op = ple_pkg::OP_RM_POS;
               default: op = ple_pkg::OP_RM_TAIL;
            endcase
         end
         removal = (op == ple_pkg::OP_RM_HEAD || op == ple_pkg::OP_RM_POS ||
                    op == ple_pkg::OP_RM_TAIL);
         queue_word(op, pick_value(), pick_position(removal));
      end
   endtask

   always @(posedge clock) begin : drive_req
      list_request_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_to_shadow_list(req_op, req_item_value, req_position);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && !sender_idles()) begin
               w = pending_words.pop_front();
               req_valid      <= 1'b1;
               req_op         <= w.op;
               req_item_value <= w.item_value;
               req_position   <= w.position;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the engine backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && words_sent >= HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left > 0) || receiver_stalls();
      end
   end

   always @(posedge clock) begin : check_rsp
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cycle %0d: unexpected word status %0d length %0d value %0d",
                        cycle_count, rsp_status, rsp_new_length, rsp_affected_value);
         end else begin
            want = predicted_results.pop_front();
            if (rsp_status !== want.status || rsp_new_length !== want.new_length ||
                rsp_affected_value !== want.affected_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: expected status %0d length %0d value %0d, %s %0d %s %0d %s %0d",
                           cycle_count, want.status, want.new_length,
                           want.affected_value, "got status", rsp_status,
                           "length", rsp_new_length, "value", rsp_affected_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      fill_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_words.size() > 0 || req_valid || predicted_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ple_pkg.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_datapath.sv
rtl/core/positional_list_engine.sv
tb/tb_top.sv
